[hw/rtl/timed_line_sequencer_macros.svh]
// assertion helpers, clocked on clk with arst_n as the disable
`ifndef TIMED_LINE_SEQUENCER_MACROS_SVH
`define TIMED_LINE_SEQUENCER_MACROS_SVH

`define TLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tls_pkg.sv]
`default_nettype none

package tls_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int OP_W      = 2;
	localparam int SLOT_W    = 4;
	localparam int DWELL_W   = 16;
	localparam int ID_W      = 32;
	localparam int ECNT_W    = 8;
	localparam int TIME_W    = 64;
	localparam int OUT_CNT_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DWELL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DWELL = 2'd1;

	localparam logic [DWELL_W-1:0] MIN_DWELL_RST = 16'd500;
	localparam logic [DWELL_W-1:0] MAX_DWELL_RST = 16'd10000;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_TICK,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		op_t                op;
		logic               slot_ok;
		logic [SLOT_W-1:0]  slot;
		logic [DWELL_W-1:0] dwell;
		logic [ID_W-1:0]    id;
		logic [ECNT_W-1:0]  cnt;
		logic [TIME_W-1:0]  now;
	} cmd_t;

	typedef struct packed {
		logic                 speaking;
		logic [OUT_CNT_W-1:0] ordinal;
		logic [OUT_CNT_W-1:0] count;
		logic [ID_W-1:0]      id;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/timed_line_sequencer.sv]
// the back end takes one command at a time and pops the next only after it has pushed the
// result of the last; a start copies its entries from the staging store into the active store,
// and a tick steps past each entry that has come due, going silent when it passes the last;
// the back end makes a single copy or catch-up step per cycle
// reset: asynchronous, active low; queues empty, sequence silent, clamps at 500 and 10000,
// staged entries undefined until loaded
`default_nettype none

module timed_line_sequencer #(
	parameter int DEPTH           = tls_pkg::DEPTH_DEF,
	parameter int CMD_QUEUE_DEPTH = tls_pkg::QUEUE_DEPTH_DEF,
	parameter int RES_QUEUE_DEPTH = tls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tls_pkg::OP_W-1:0]      opcode,
	input  logic [tls_pkg::SLOT_W-1:0]    slot,
	input  logic [tls_pkg::DWELL_W-1:0]   dwell_ms,
	input  logic [tls_pkg::ID_W-1:0]      line_id,
	input  logic [tls_pkg::ECNT_W-1:0]    entry_count,
	input  logic [tls_pkg::TIME_W-1:0]    now,
	output logic                          empty,
	input  logic                          pop,
	output logic                          is_speaking,
	output logic [tls_pkg::OUT_CNT_W-1:0] line_ordinal,
	output logic [tls_pkg::OUT_CNT_W-1:0] active_count,
	output logic [tls_pkg::ID_W-1:0]      current_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tls_pkg::DWELL_W-1:0]   cfg_data
);

	import tls_pkg::*;

	logic [DWELL_W-1:0]      min_dwell_q;
	logic [DWELL_W-1:0]      max_dwell_q;
	logic                    cmd_pop;
	logic                    cmd_empty;
	cmd_t                    cmd;
	logic                    res_push;
	logic                    res_full;
	res_t                    res;
	res_t                    res_out;
	logic [$bits(res_t)-1:0] res_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dwell_q <= MIN_DWELL_RST;
			max_dwell_q <= MAX_DWELL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_DWELL: min_dwell_q <= cfg_data;
				REG_MAX_DWELL: max_dwell_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tls_front #(
		.DEPTH  (DEPTH),
		.QDEPTH (CMD_QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.slot        (slot),
		.dwell_ms    (dwell_ms),
		.line_id     (line_id),
		.entry_count (entry_count),
		.now         (now),
		.cmd_pop     (cmd_pop),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd)
	);

	tls_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.min_dwell (min_dwell_q),
		.max_dwell (max_dwell_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	tls_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_raw),
		.empty  (empty)
	);

	assign res_out      = res_t'(res_raw);
	assign is_speaking  = res_out.speaking;
	assign line_ordinal = res_out.ordinal;
	assign active_count = res_out.count;
	assign current_id   = res_out.id;

endmodule

`default_nettype wire

[hw/rtl/tls_fifo.sv]
`default_nettype none
`include "timed_line_sequencer_macros.svh"

module tls_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = tls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + CNT_W'(1);
				2'b01: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`TLS_ASSERT_NEXT(a_fifo_fill, wr_en && !rd_en, !empty, "queue lost a write")
	`TLS_ASSERT_NEXT(a_fifo_drain, rd_en && !wr_en && cnt_q == CNT_W'(1), empty, "queue kept a read entry")

endmodule

`default_nettype wire

[hw/rtl/tls_front.sv]
`default_nettype none

module tls_front #(
	parameter int DEPTH  = tls_pkg::DEPTH_DEF,
	parameter int QDEPTH = tls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [tls_pkg::OP_W-1:0]      opcode,
	input  logic [tls_pkg::SLOT_W-1:0]    slot,
	input  logic [tls_pkg::DWELL_W-1:0]   dwell_ms,
	input  logic [tls_pkg::ID_W-1:0]      line_id,
	input  logic [tls_pkg::ECNT_W-1:0]    entry_count,
	input  logic [tls_pkg::TIME_W-1:0]    now,
	input  logic                          cmd_pop,
	output logic                          cmd_empty,
	output tls_pkg::cmd_t                 cmd
);

	import tls_pkg::*;

	cmd_t                cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	// saturate the count and flag loads that fall outside the store
	always_comb begin
		cmd_in.op      = op_t'(opcode);
		cmd_in.slot_ok = (int'(slot) < DEPTH);
		cmd_in.slot    = slot;
		cmd_in.dwell   = dwell_ms;
		cmd_in.id      = line_id;
		cmd_in.cnt     = (int'(entry_count) > DEPTH) ? ECNT_W'(DEPTH) : entry_count;
		cmd_in.now     = now;
	end

	tls_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QDEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

`default_nettype wire

[hw/rtl/tls_back.sv]
`default_nettype none
`include "timed_line_sequencer_macros.svh"

module tls_back #(
	parameter int DEPTH = tls_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  tls_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic [tls_pkg::DWELL_W-1:0] min_dwell,
	input  logic [tls_pkg::DWELL_W-1:0] max_dwell,
	input  logic                        res_full,
	output logic                        res_push,
	output tls_pkg::res_t               res
);

	import tls_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DWELL_W-1:0] stg_dwell_q [DEPTH];
	logic [ID_W-1:0]    stg_id_q    [DEPTH];
	logic [DWELL_W-1:0] act_dwell_q [DEPTH];
	logic [ID_W-1:0]    act_id_q    [DEPTH];

	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [TIME_W-1:0]  tick_now_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [IDX_W-1:0]   cp_q;
	logic [TIME_W-1:0]  lst_q;
	logic               speaking_q;

	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_slot;
	logic [CNT_W-1:0]   cnt_in;
	logic [CNT_W-1:0]   idx_nxt;
	logic [DWELL_W-1:0] cur_dwell;
	logic [DWELL_W-1:0] lo_dwell;
	logic [DWELL_W-1:0] clamp_dwell;
	logic [TIME_W:0]    due_time;
	logic               adv;
	logic               last;
	logic               copy_last;
	logic               showing;

	assign rd_idx    = idx_q[IDX_W-1:0];
	assign wr_slot   = IDX_W'(cmd.slot);
	assign cnt_in    = CNT_W'(cmd.cnt);
	assign idx_nxt   = idx_q + CNT_W'(1);
	assign last      = (idx_nxt >= count_q);
	assign copy_last = ((CNT_W'(cp_q) + CNT_W'(1)) == count_q);

	// lower clamp first, then upper
	assign cur_dwell   = act_dwell_q[rd_idx];
	assign lo_dwell    = (cur_dwell < min_dwell) ? min_dwell : cur_dwell;
	assign clamp_dwell = (lo_dwell > max_dwell) ? max_dwell : lo_dwell;
	assign due_time    = {1'b0, lst_q} + (TIME_W + 1)'(clamp_dwell);
	assign adv         = speaking_q && ({1'b0, tick_now_q} >= due_time);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.op)
						OP_START: state_d = (cnt_in == '0) ? ST_DONE : ST_COPY;
						OP_TICK:  state_d = ST_TICK;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_COPY: begin
				if (copy_last) begin
					state_d = ST_DONE;
				end
			end
			ST_TICK: begin
				if (!(adv && !last)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop      = (state_q == ST_IDLE) && !cmd_empty;
		res_push     = (state_q == ST_DONE) && !res_full;
		showing      = speaking_q && (idx_q < count_q);
		res.speaking = speaking_q;
		res.ordinal  = showing ? OUT_CNT_W'(idx_q) + OUT_CNT_W'(1) : '0;
		res.count    = OUT_CNT_W'(count_q);
		res.id       = showing ? act_id_q[rd_idx] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			cp_q       <= '0;
			lst_q      <= '0;
			speaking_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.op == OP_START) begin
						count_q    <= cnt_in;
						idx_q      <= '0;
						cp_q       <= '0;
						lst_q      <= (cnt_in == '0) ? '0 : cmd.now;
						speaking_q <= (cnt_in != '0);
					end else if (cmd_pop && cmd.op == OP_STOP) begin
						count_q    <= '0;
						idx_q      <= '0;
						lst_q      <= '0;
						speaking_q <= 1'b0;
					end
				end
				ST_COPY: begin
					cp_q <= cp_q + IDX_W'(1);
				end
				ST_TICK: begin
					if (adv) begin
						if (last) begin
							count_q    <= '0;
							idx_q      <= '0;
							lst_q      <= '0;
							speaking_q <= 1'b0;
						end else begin
							idx_q <= idx_nxt;
							lst_q <= due_time[TIME_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry stores, contents only meaningful below the live count
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			tick_now_q <= cmd.now;
		end
		if (cmd_pop && cmd.op == OP_LOAD && cmd.slot_ok) begin
			stg_dwell_q[wr_slot] <= cmd.dwell;
			stg_id_q[wr_slot]    <= cmd.id;
		end
		if (state_q == ST_COPY) begin
			act_dwell_q[cp_q] <= stg_dwell_q[cp_q];
			act_id_q[cp_q]    <= stg_id_q[cp_q];
		end
	end

	`TLS_ASSERT_IMP(a_copy_live, state_q == ST_COPY, speaking_q && count_q != '0, "copy idle")
	`TLS_ASSERT_IMP(a_idx_in_range, speaking_q, idx_q < count_q, "line index beyond count")
	`TLS_ASSERT_IMP(a_silent_clear, !speaking_q, count_q == '0 && idx_q == '0, "silent, not clear")

endmodule

`default_nettype wire
